>>> rtl/ksp_pkg.sv
// Shared constants, command/status types for the plucked-string voice.
package ksp_pkg;

   // delay line geometry
   localparam int MAX_LEN   = 1024;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int MIN_LEN   = 8;
   localparam int LOOP_IN_W = 12;

   // sample and register widths
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int ATTACK_W   = 16;
   localparam int LIFE_W     = 18;
   localparam int REQ_DATA_W = ((LOOP_IN_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIFE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFE   = 2'd2;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd31457;
   localparam logic [ATTACK_W-1:0] ATTACK_RESET = 16'd144;
   localparam logic [LIFE_W-1:0]   LIFE_RESET   = 18'd48000;
   localparam logic [LIFE_W-1:0]   ELAPSED_MAX  = {LIFE_W{1'b1}};

   // envelope arithmetic, Q.16 values up to and including one
   localparam int Q16_W = 17;
   localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
   localparam int DIV_STEPS = Q16_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // noise generator and loop filter
   localparam logic [31:0] LCG_MUL    = 32'd1103515245;
   localparam logic [31:0] LCG_INC    = 32'd12345;
   localparam logic [31:0] SEED_RESET = 32'd12345;
   localparam logic [15:0] DAMP       = 16'd32637;

   // request kinds carried in tuser
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_PLUCK = 1'b1;

   typedef struct packed {
      logic pluck_start;
      logic fill_step;
      logic kill;
      logic rd_nxt;
      logic wrbk;
      logic div_start;
      logic div_sel;      // 0: attack ramp, 1: decay
      logic latch_a;
      logic latch_d;
      logic mul_d2;
      logic mul_env;
      logic mul_ce;
      logic finish;
      logic load_out;
   } ksp_cmd_type;

   typedef struct packed {
      logic live;
      logic fill_last;
      logic attack_run;
      logic div_done;
   } ksp_status_type;

endpackage

>>> rtl/ksp_ram.sv
// Generic simple dual-port RAM with registered read.
module ksp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ksp_div.sv
// Restoring divider, one quotient bit per cycle, for the Q.16 envelope ratios.
module ksp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ksp_pkg::LIFE_W-1:0]  num,
   input  logic [ksp_pkg::LIFE_W-1:0]  den,
   output logic                        done,
   output logic [ksp_pkg::Q16_W-1:0]   quo
);

   logic [ksp_pkg::LIFE_W:0]          rem_ff;
   logic [ksp_pkg::LIFE_W-1:0]        den_ff;
   logic [ksp_pkg::Q16_W-1:0]         quo_ff;
   logic [ksp_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;

   logic [ksp_pkg::LIFE_W:0] rem_sh;
   logic [ksp_pkg::LIFE_W:0] rem_dif;
   logic                     ge;

   // first step takes the numerator as is (num <= den), later steps shift
   assign rem_sh  = (cnt_ff == ksp_pkg::DIV_CNT_W'(ksp_pkg::DIV_STEPS)) ? rem_ff
                  : {rem_ff[ksp_pkg::LIFE_W-1:0], 1'b0};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_dif = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ksp_pkg::DIV_CNT_W'(ksp_pkg::DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - ksp_pkg::DIV_CNT_W'(1);
            if (cnt_ff == ksp_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_dif : rem_sh;
         quo_ff <= {quo_ff[ksp_pkg::Q16_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> rtl/ksp_dp.sv
// Datapath: delay line, noise source, loop filter, envelope and output registers.
module ksp_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ksp_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [ksp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [ksp_pkg::LOOP_IN_W-1:0]     loop_length,
   input  ksp_pkg::ksp_cmd_type              cmd,
   output ksp_pkg::ksp_status_type           status,
   output logic [ksp_pkg::SAMPLE_W-1:0]      sample,
   output logic                              active
);

   // configuration
   logic [ksp_pkg::GAIN_W-1:0]   gain_ff;
   logic [ksp_pkg::ATTACK_W-1:0] attack_ff;
   logic [ksp_pkg::LIFE_W-1:0]   life_ff;

   // voice state
   logic [ksp_pkg::ADDR_W-1:0]   pos_ff;
   logic [ksp_pkg::LEN_W-1:0]    loop_len_ff;
   logic [ksp_pkg::LEN_W-1:0]    fill_cnt_ff;
   logic [ksp_pkg::LIFE_W-1:0]   elapsed_ff;
   logic                         voice_on_ff;
   logic [31:0]                  seed_ff;

   // working registers
   logic signed [ksp_pkg::SAMPLE_W-1:0] cur_ff;
   logic [ksp_pkg::Q16_W-1:0]           a_ff;
   logic [ksp_pkg::Q16_W-1:0]           d_ff;
   logic [ksp_pkg::Q16_W-1:0]           d2_ff;
   logic [ksp_pkg::Q16_W-1:0]           env_ff;
   logic signed [33:0]                  ce_ff;
   logic [ksp_pkg::SAMPLE_W-1:0]        res_sample_ff;
   logic                                res_active_ff;
   logic [ksp_pkg::SAMPLE_W-1:0]        out_sample_ff;
   logic                                out_active_ff;

   logic [ksp_pkg::LEN_W-1:0]    len_clamped;
   logic [ksp_pkg::ADDR_W-1:0]   pos_eff;
   logic [ksp_pkg::LEN_W-1:0]    nx_wide;
   logic [ksp_pkg::ADDR_W-1:0]   nx_pos;

   logic [31:0]                  seed_nx;
   logic [14:0]                  noise_r;
   logic signed [16:0]           noise_wide;

   logic                         ram_we;
   logic [ksp_pkg::ADDR_W-1:0]   ram_waddr;
   logic [ksp_pkg::SAMPLE_W-1:0] ram_wdata;
   logic [ksp_pkg::ADDR_W-1:0]   ram_raddr;
   logic [ksp_pkg::SAMPLE_W-1:0] ram_rdata;

   logic signed [16:0]           fb_sum;
   logic signed [32:0]           fb_prod;

   logic [ksp_pkg::LIFE_W-1:0]   div_num;
   logic [ksp_pkg::LIFE_W-1:0]   div_den;
   logic                         div_done;
   logic [ksp_pkg::Q16_W-1:0]    div_quo;

   logic [33:0]                  d_sq;
   logic [33:0]                  a_d2;
   logic signed [33:0]           ce_prod;
   logic signed [50:0]           g_prod;
   logic signed [18:0]           g_shift;
   logic [ksp_pkg::SAMPLE_W-1:0] g_clamp;

   always_comb begin
      if (32'(loop_length) < ksp_pkg::MIN_LEN) begin
         len_clamped = ksp_pkg::LEN_W'(ksp_pkg::MIN_LEN);
      end else if (32'(loop_length) > ksp_pkg::MAX_LEN) begin
         len_clamped = ksp_pkg::LEN_W'(ksp_pkg::MAX_LEN);
      end else begin
         len_clamped = ksp_pkg::LEN_W'(loop_length);
      end
   end

   // loop position and its successor, both wrapped at the loop length
   assign pos_eff = ({1'b0, pos_ff} >= loop_len_ff) ? '0 : pos_ff;
   assign nx_wide = {1'b0, pos_eff} + ksp_pkg::LEN_W'(1);
   assign nx_pos  = (nx_wide >= loop_len_ff) ? '0 : nx_wide[ksp_pkg::ADDR_W-1:0];

   // noise: LCG, bits 30..16 mapped to 2r - 32767
   assign seed_nx    = seed_ff * ksp_pkg::LCG_MUL + ksp_pkg::LCG_INC;
   assign noise_r    = seed_nx[30:16];
   assign noise_wide = $signed({1'b0, noise_r, 1'b0}) - 17'sd32767;

   // loop filter on the current entry and the one after it
   assign fb_sum  = {cur_ff[ksp_pkg::SAMPLE_W-1], cur_ff}
                  + {ram_rdata[ksp_pkg::SAMPLE_W-1], ram_rdata};
   assign fb_prod = fb_sum * $signed({1'b0, ksp_pkg::DAMP});

   assign ram_we    = cmd.fill_step | cmd.wrbk;
   assign ram_waddr = cmd.fill_step ? fill_cnt_ff[ksp_pkg::ADDR_W-1:0] : pos_eff;
   assign ram_wdata = cmd.fill_step ? noise_wide[ksp_pkg::SAMPLE_W-1:0] : fb_prod[31:16];
   assign ram_raddr = cmd.rd_nxt ? nx_pos : pos_eff;

   ksp_ram #(
      .WIDTH (ksp_pkg::SAMPLE_W),
      .DEPTH (ksp_pkg::MAX_LEN)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign div_num = cmd.div_sel ? (life_ff - elapsed_ff) : elapsed_ff;
   assign div_den = cmd.div_sel ? life_ff : ksp_pkg::LIFE_W'(attack_ff);

   ksp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign d_sq    = d_ff * d_ff;
   assign a_d2    = a_ff * d2_ff;
   assign ce_prod = cur_ff * $signed({1'b0, env_ff});
   assign g_prod  = ce_ff * $signed({1'b0, gain_ff});
   assign g_shift = g_prod[50:32];

   always_comb begin
      if (g_shift > 19'sd32767) begin
         g_clamp = 16'h7fff;
      end else if (g_shift < -19'sd32768) begin
         g_clamp = 16'h8000;
      end else begin
         g_clamp = g_shift[ksp_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= ksp_pkg::GAIN_RESET;
         attack_ff <= ksp_pkg::ATTACK_RESET;
         life_ff   <= ksp_pkg::LIFE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ksp_pkg::CSR_GAIN:   gain_ff   <= csr_wdata[ksp_pkg::GAIN_W-1:0];
            ksp_pkg::CSR_ATTACK: attack_ff <= csr_wdata[ksp_pkg::ATTACK_W-1:0];
            ksp_pkg::CSR_LIFE:   life_ff   <= csr_wdata[ksp_pkg::LIFE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         loop_len_ff <= ksp_pkg::LEN_W'(ksp_pkg::MIN_LEN);
         fill_cnt_ff <= '0;
         elapsed_ff  <= '0;
         voice_on_ff <= 1'b0;
         seed_ff     <= ksp_pkg::SEED_RESET;
      end else begin
         if (cmd.pluck_start) begin
            loop_len_ff <= len_clamped;
            pos_ff      <= '0;
            fill_cnt_ff <= '0;
            elapsed_ff  <= '0;
            voice_on_ff <= 1'b1;
         end
         if (cmd.fill_step) begin
            seed_ff     <= seed_nx;
            fill_cnt_ff <= fill_cnt_ff + ksp_pkg::LEN_W'(1);
         end
         if (cmd.kill) begin
            voice_on_ff <= 1'b0;
         end
         if (cmd.wrbk) begin
            pos_ff <= nx_pos;
         end
         if (cmd.finish && elapsed_ff != ksp_pkg::ELAPSED_MAX) begin
            elapsed_ff <= elapsed_ff + ksp_pkg::LIFE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_nxt) begin
         cur_ff <= ram_rdata;
      end
      if (cmd.wrbk || cmd.latch_a) begin
         a_ff <= cmd.latch_a ? div_quo : ksp_pkg::ONE_Q16;
      end
      if (cmd.latch_d) begin
         d_ff <= div_quo;
      end
      if (cmd.mul_d2) begin
         d2_ff <= d_sq[32:16];
      end
      if (cmd.mul_env) begin
         env_ff <= a_d2[32:16];
      end
      if (cmd.mul_ce) begin
         ce_ff <= ce_prod;
      end
      if (cmd.kill) begin
         res_sample_ff <= '0;
         res_active_ff <= 1'b0;
      end else if (cmd.finish) begin
         res_sample_ff <= g_clamp;
         res_active_ff <= 1'b1;
      end
      if (cmd.load_out) begin
         out_sample_ff <= res_sample_ff;
         out_active_ff <= res_active_ff;
      end
   end

   assign status.live       = voice_on_ff && (elapsed_ff < life_ff);
   assign status.fill_last  = (fill_cnt_ff == loop_len_ff - ksp_pkg::LEN_W'(1));
   assign status.attack_run = (elapsed_ff < ksp_pkg::LIFE_W'(attack_ff));
   assign status.div_done   = div_done;

   assign sample = out_sample_ff;
   assign active = out_active_ff;

endmodule

>>> rtl/ksp_ctrl.sv
// Controller: sequences pluck fill, tick read/modify/write, envelope and output.
module ksp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_func,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  ksp_pkg::ksp_status_type  status,
   output ksp_pkg::ksp_cmd_type     cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FILL  = 4'd1;
   localparam logic [3:0] ST_RDCUR = 4'd2;
   localparam logic [3:0] ST_RDNXT = 4'd3;
   localparam logic [3:0] ST_WRBK  = 4'd4;
   localparam logic [3:0] ST_A_ST  = 4'd5;
   localparam logic [3:0] ST_A_WT  = 4'd6;
   localparam logic [3:0] ST_D_ST  = 4'd7;
   localparam logic [3:0] ST_D_WT  = 4'd8;
   localparam logic [3:0] ST_M_D2  = 4'd9;
   localparam logic [3:0] ST_M_ENV = 4'd10;
   localparam logic [3:0] ST_M_CE  = 4'd11;
   localparam logic [3:0] ST_M_G   = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == ksp_pkg::FUNC_PLUCK) begin
                  cmd.pluck_start = 1'b1;
                  state_in        = ST_FILL;
               end else if (status.live) begin
                  state_in = ST_RDCUR;
               end else begin
                  cmd.kill = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RDCUR: state_in = ST_RDNXT;
         ST_RDNXT: begin
            cmd.rd_nxt = 1'b1;
            state_in   = ST_WRBK;
         end
         ST_WRBK: begin
            cmd.wrbk = 1'b1;
            state_in = status.attack_run ? ST_A_ST : ST_D_ST;
         end
         ST_A_ST: begin
            cmd.div_start = 1'b1;
            state_in      = ST_A_WT;
         end
         ST_A_WT: begin
            if (status.div_done) begin
               cmd.latch_a = 1'b1;
               state_in    = ST_D_ST;
            end
         end
         ST_D_ST: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = ST_D_WT;
         end
         ST_D_WT: begin
            if (status.div_done) begin
               cmd.latch_d = 1'b1;
               state_in    = ST_M_D2;
            end
         end
         ST_M_D2: begin
            cmd.mul_d2 = 1'b1;
            state_in   = ST_M_ENV;
         end
         ST_M_ENV: begin
            cmd.mul_env = 1'b1;
            state_in    = ST_M_CE;
         end
         ST_M_CE: begin
            cmd.mul_ce = 1'b1;
            state_in   = ST_M_G;
         end
         ST_M_G: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold the result until the output register frees up
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_A_WT || state_ff == ST_D_WT))
      else $error("divider finished outside a wait state");

   a_pluck_enters_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && req_func == ksp_pkg::FUNC_PLUCK)
      |=> state_ff == ST_FILL)
      else $error("pluck transaction did not start the fill");

   a_pending_result_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_tvalid_ff && !rsp_tready) |=> state_ff == ST_OUT)
      else $error("new result overwrote one still pending");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

endmodule

>>> rtl/karplus_strong_pluck_voice.sv
// Top level of the plucked-string voice: controller, datapath and port wiring.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: loop_length; tuser: func
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: sample; tuser: active
//   csr_     in   csr_we                 csr_addr, csr_wdata
//
// A live tick runs the shared 17-step divider once for the decay and, while the
// attack ramp runs, once more for the ramp. A tick on a silent voice goes
// straight to the output stage. A pluck fills the loop with noise, one delay
// entry written per cycle.
// Reset is synchronous; the delay line has no clearing pass.
// A stalled result holds in the output register; the next transaction is taken
// and worked on, and waits only at its own result.
module karplus_strong_pluck_voice (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ksp_pkg::REQ_DATA_W-1:0]    req_tdata,   // [11:0] loop_length
   input  logic [0:0]                        req_tuser,   // [0] func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ksp_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] sample
   output logic [0:0]                        rsp_tuser,   // [0] active
   input  logic                              csr_we,
   input  logic [ksp_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [ksp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ksp_pkg::ksp_cmd_type          cmd;
   ksp_pkg::ksp_status_type       status;
   logic [ksp_pkg::SAMPLE_W-1:0]  sample;
   logic                          active;

   ksp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ksp_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .loop_length (req_tdata[ksp_pkg::LOOP_IN_W-1:0]),
      .cmd         (cmd),
      .status      (status),
      .sample      (sample),
      .active      (active)
   );

   assign rsp_tdata = ksp_pkg::RSP_DATA_W'(sample);
   assign rsp_tuser = active;

endmodule

>>> sim/karplus_strong_pluck_voice_tb.sv
// Self-checking testbench for the plucked-string voice: stream stimulus, scoreboard, CSR phases.
module karplus_strong_pluck_voice_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ksp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT     = 1_200_000;
   localparam int unsigned PLUCK_SETTLE    = MAX_LEN + 32;
   localparam int unsigned TAIL_CYCLES     = 64;
   localparam int unsigned RAND_PHASES     = 7;
   localparam int unsigned ITEMS_PER_PHASE = 245;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                active;
   } voice_result_type;

   class voice_scoreboard;
      logic signed [SAMPLE_W-1:0] string_line [MAX_LEN];
      logic [ADDR_W-1:0]   read_pos;
      logic [LEN_W-1:0]    loop_len;
      logic [LIFE_W-1:0]   elapsed;
      logic                sounding;
      logic [31:0]         noise_seed;
      logic [GAIN_W-1:0]   gain;
      logic [ATTACK_W-1:0] attack_len;
      logic [LIFE_W-1:0]   life_len;
      voice_result_type    expected_samples [$];
      int unsigned         errors;

      function new();
         foreach (string_line[i]) string_line[i] = '0;
         read_pos   = '0;
         loop_len   = LEN_W'(MIN_LEN);
         elapsed    = '0;
         sounding   = 1'b0;
         noise_seed = SEED_RESET;
         gain       = GAIN_RESET;
         attack_len = ATTACK_RESET;
         life_len   = LIFE_RESET;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GAIN:   gain = data[GAIN_W-1:0];
            CSR_ATTACK: attack_len = data[ATTACK_W-1:0];
            CSR_LIFE:   life_len = data[LIFE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      function void note_request(logic func, logic [LOOP_IN_W-1:0] len_field);
         int unsigned   n, i, t, nx;
         longint        cur, nxt, a, d, d2, env, s;
         if (func == FUNC_PLUCK) begin
            n = 32'(len_field);
            if (n < MIN_LEN) n = MIN_LEN;
            if (n > MAX_LEN) n = MAX_LEN;
            loop_len = LEN_W'(n);
            read_pos = '0;
            // fill the loop with LCG noise, bits 30..16 mapped to 2r-32767
            for (i = 0; i < n; i++) begin
               noise_seed = noise_seed * LCG_MUL + LCG_INC;
               string_line[i] = SAMPLE_W'(2 * int'({1'b0, noise_seed[30:16]}) - 32767);
            end
            elapsed  = '0;
            sounding = 1'b1;
            return;
         end
         if (!sounding || elapsed >= life_len) begin
            sounding = 1'b0;
            expected_samples.push_back('{sample: '0, active: 1'b0});
            return;
         end
         t = 32'(elapsed);
         if (read_pos >= loop_len) read_pos = '0;
         nx = read_pos + 1;
         if (nx >= loop_len) nx = 0;
         cur = longint'(string_line[read_pos]);
         nxt = longint'(string_line[nx]);
         string_line[read_pos] = SAMPLE_W'(((cur + nxt) * longint'(DAMP)) >>> 16);
         read_pos = ADDR_W'(nx);

         if (t < attack_len) a = (longint'(t) << 16) / longint'(attack_len);
         else a = longint'(ONE_Q16);
         d   = ((longint'(life_len) - longint'(t)) << 16) / longint'(life_len);
         d2  = (d * d) >>> 16;
         env = (a * d2) >>> 16;
         s   = (cur * env * longint'(gain)) >>> 32;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         if (elapsed < ELAPSED_MAX) elapsed++;
         expected_samples.push_back('{sample: SAMPLE_W'(s), active: 1'b1});
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] got_sample, logic got_active);
         voice_result_type want;
         if (expected_samples.size() == 0) begin
            $error("unexpected result: sample %0d active %0d", $signed(got_sample), got_active);
            errors++;
            return;
         end
         want = expected_samples.pop_front();
         if (got_sample !== want.sample) begin
            $error("sample mismatch: expected %0d, actual %0d",
                   $signed(want.sample), $signed(got_sample));
            errors++;
         end
         if (got_active !== want.active) begin
            $error("active mismatch: expected %0d, actual %0d", want.active, got_active);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [11:0] loop_length
   logic [0:0]            req_tuser  = '0;   // [0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [15:0] sample
   logic [0:0]            rsp_tuser;         // [0] active
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   voice_scoreboard sb;
   bit              steady_flow = 1'b0;
   int unsigned     items_sent  = 0;
   int unsigned     cycle_count = 0;

   karplus_strong_pluck_voice dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("karplus_strong_pluck_voice_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[SAMPLE_W-1:0], rsp_tuser[0]);
   end

   // receiver: random stall bursts until the last phase
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 9);
         end
      end
   end

   function automatic logic [LOOP_IN_W-1:0] pick_loop_length();
      int unsigned roll;
      roll = $urandom_range(0, 39);
      if (roll == 0) return LOOP_IN_W'($urandom_range(MAX_LEN, 4095));
      if (roll < 4) return LOOP_IN_W'($urandom_range(0, MIN_LEN));
      return LOOP_IN_W'($urandom_range(MIN_LEN, 48));
   endfunction

   // call at a falling edge; returns at the falling edge after the transaction
   task automatic send_item(input logic func, input logic [LOOP_IN_W-1:0] len);
      if (!steady_flow && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= REQ_DATA_W'(len);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, len);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // hold off until a trailing pluck fill is surely done, then rewrite all registers
   task automatic reconfigure(input int unsigned g, input int unsigned atk,
                              input int unsigned life_v);
      pause_until_drained();
      repeat (PLUCK_SETTLE) @(negedge clock);
      csr_write(CSR_GAIN, {(CSR_DATA_W-GAIN_W)'($urandom), GAIN_W'(g)});
      csr_write(CSR_ATTACK, {(CSR_DATA_W-ATTACK_W)'($urandom), ATTACK_W'(atk)});
      csr_write(CSR_LIFE, LIFE_W'(life_v));
   endtask

   initial begin
      int unsigned phase, target, run, roll;
      sb = new();
      wait (!reset);
      @(negedge clock);

      // reset settings: silent tick, clamped lengths, re-pluck while sounding
      send_item(FUNC_TICK, '1);
      send_item(FUNC_PLUCK, 12'd0);
      repeat (3) send_item(FUNC_TICK, 12'd0);
      send_item(FUNC_PLUCK, 12'd4095);
      repeat (2) send_item(FUNC_TICK, 12'hAAA);
      send_item(FUNC_PLUCK, 12'd7);
      send_item(FUNC_TICK, 12'h555);

      // full gain, no ramp, one-sample life: end of life then silent tick
      reconfigure(65535, 0, 1);
      send_item(FUNC_PLUCK, 12'd8);
      repeat (3) send_item(FUNC_TICK, 12'd0);

      // zero gain, zero life; the spare index must be ignored
      reconfigure(0, 1, 0);
      csr_write(CSR_SPARE, '1);
      send_item(FUNC_PLUCK, 12'd9);
      send_item(FUNC_TICK, 12'd0);

      // longest ramp and life
      reconfigure(40000, 65535, 32'(ELAPSED_MAX));
      send_item(FUNC_PLUCK, 12'd2049);
      repeat (2) send_item(FUNC_TICK, 12'd0);
      send_item(FUNC_PLUCK, 12'd1024);
      send_item(FUNC_TICK, 12'd0);

      for (phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0: reconfigure(65535, 1, 32'(ELAPSED_MAX));
            1: reconfigure(0, 65535, $urandom_range(20, 60));
            2: reconfigure($urandom_range(0, 65535), 0, $urandom_range(1, 80));
            default: reconfigure($urandom_range(0, 65535), $urandom_range(0, 100),
                                 $urandom_range(0, 100));
         endcase
         if (phase == RAND_PHASES - 1) steady_flow = 1'b1;
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            roll = $urandom_range(0, 19);
            if (roll < 16) begin
               // a note: pluck, then a run of ticks that often outlives the voice
               send_item(FUNC_PLUCK, pick_loop_length());
               run = $urandom_range(1, 90);
               repeat (run) send_item(FUNC_TICK, LOOP_IN_W'($urandom));
            end else if (roll < 18) begin
               send_item(FUNC_TICK, LOOP_IN_W'($urandom));
            end else if (roll == 18) begin
               send_item(FUNC_PLUCK, pick_loop_length());
            end else begin
               pause_until_drained();
            end
         end
      end

      pause_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("karplus_strong_pluck_voice_tb: PASS");
      end else begin
         $display("karplus_strong_pluck_voice_tb: FAIL");
      end
      $finish;
   end

endmodule
